### hdl/gcdlcm_pkg.sv
// Package for the GCD / LCM unit: operand width, transaction payload types,
// sequencer states and the request and response types of the shared adder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package gcdlcm_pkg;

  // Number of operand bits that take part in the computation (4 to 32).
  localparam int unsigned OPERAND_WIDTH = 32;

  // The shared adder is wide enough for the double-width product.
  localparam int unsigned ALU_WIDTH = 2 * OPERAND_WIDTH;

  // Iteration and shift counters hold values up to OPERAND_WIDTH - 1.
  localparam int unsigned CNT_WIDTH = $clog2(OPERAND_WIDTH);

  // Input transaction.
  typedef struct packed {
    logic [31:0] first_operand;
    logic [31:0] second_operand;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] gcd_value;
    logic [63:0] lcm_value;
    logic        operand_error;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TWOS,
    ST_REDUCE,
    ST_SCALE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } gcdlcm_state_t;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  // Request to the shared adder.
  typedef struct packed {
    alu_op_t              op;
    logic [ALU_WIDTH-1:0] opa;
    logic [ALU_WIDTH-1:0] opb;
  } alu_req_t;

  // Response of the shared adder: sum or difference, and carry or borrow.
  typedef struct packed {
    logic [ALU_WIDTH-1:0] res;
    logic                 flag;
  } alu_rsp_t;

endpackage

`default_nettype wire

### hdl/gcdlcm_addsub.sv
// Shared add / subtract unit of the GCD / LCM unit.
// Depends on gcdlcm_pkg for the request and response types.
`default_nettype none

module gcdlcm_addsub (
  input  wire gcdlcm_pkg::alu_req_t req,
  output gcdlcm_pkg::alu_rsp_t      rsp
);
  import gcdlcm_pkg::*;

  logic [ALU_WIDTH:0] ext;

  // One carry chain serves both operations; the top bit is carry on add and
  // borrow on subtract.
  always_comb begin
    case (req.op)
      ALU_ADD: ext = {1'b0, req.opa} + {1'b0, req.opb};
      ALU_SUB: ext = {1'b0, req.opa} - {1'b0, req.opb};
      default: ext = '0;
    endcase
  end

  assign rsp.res  = ext[ALU_WIDTH-1:0];
  assign rsp.flag = ext[ALU_WIDTH];

endmodule

`default_nettype wire

### hdl/gcd_lcm_unit.sv
// Top level of the GCD / LCM unit: sequencer, operand registers and result
// register. Depends on gcdlcm_pkg and instantiates gcdlcm_addsub.
//
//   channel | ports                          | direction | payload
//   --------+--------------------------------+-----------+-------------------
//   input   | in_valid, in_stall, in_data    | into unit | in_item_t
//   result  | out_valid, out_stall, out_data | out of it | out_item_t
//
// One transaction at a time runs through a single shared adder. The GCD is
// found by binary GCD (common twos, odd reduction, rescale), then a/g by a
// restoring divide of OPERAND_WIDTH steps and (a/g)*b by shift-add of
// OPERAND_WIDTH steps. The length of a transaction depends on the data in the
// GCD loops; a zero operand goes straight to the result. Reset is synchronous
// and active low and clears the sequencer and the result valid. A stalled
// result stays in the output register while the next transaction is
// accepted and computed.
`default_nettype none

module gcd_lcm_unit (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire gcdlcm_pkg::in_item_t  in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output gcdlcm_pkg::out_item_t      out_data
);
  import gcdlcm_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  gcdlcm_state_t state_r, state_nxt;

  logic [W-1:0]         x_r, x_nxt;
  logic [W-1:0]         y_r, y_nxt;
  logic [W-1:0]         a_r, a_nxt;
  logic [W-1:0]         b_r, b_nxt;
  logic [W-1:0]         q_r, q_nxt;
  logic [W-1:0]         rem_r, rem_nxt;
  logic [ALU_WIDTH-1:0] acc_r, acc_nxt;
  logic [CNT_WIDTH-1:0] k_r, k_nxt;
  logic [CNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                 swap_r, swap_nxt;
  logic                 err_r, err_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic [W-1:0] in_a;
  logic [W-1:0] in_b;
  logic         in_accept;
  logic         in_zero;
  logic         xy_equal;
  logic         last_step;
  logic         out_load;
  logic [W:0]   trial;
  logic [W-1:0] diff_half;

  // Operands masked to the working width.
  assign in_a      = in_data.first_operand[W-1:0];
  assign in_b      = in_data.second_operand[W-1:0];
  assign in_zero   = (in_a == '0) || (in_b == '0);
  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);

  assign xy_equal  = (x_r == y_r);
  assign last_step = (cnt_r == CNT_WIDTH'(W - 1));
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  // Divide step: shift the next dividend bit into the partial remainder.
  assign trial     = {rem_r, q_r[W-1]};
  assign diff_half = {1'b0, alu_rsp.res[W-1:1]};

  gcdlcm_addsub u_addsub (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = in_zero ? ST_DONE : ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (x_r[0] || y_r[0]) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (xy_equal) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (k_r == '0) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_step) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Operand selection for the shared adder.
  always_comb begin
    alu_req.op  = ALU_SUB;
    alu_req.opa = ALU_WIDTH'(swap_r ? y_r : x_r);
    alu_req.opb = ALU_WIDTH'(swap_r ? x_r : y_r);
    case (state_r)
      ST_DIV: begin
        alu_req.op  = ALU_SUB;
        alu_req.opa = ALU_WIDTH'(trial);
        alu_req.opb = ALU_WIDTH'(x_r);
      end
      ST_MUL: begin
        alu_req.op  = ALU_ADD;
        alu_req.opa = {acc_r[ALU_WIDTH-2:0], 1'b0};
        alu_req.opb = q_r[W-1] ? ALU_WIDTH'(b_r) : '0;
      end
      default: begin
      end
    endcase
  end

  // Datapath register updates for each state.
  always_comb begin
    x_nxt        = x_r;
    y_nxt        = y_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    q_nxt        = q_r;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    k_nxt        = k_r;
    cnt_nxt      = cnt_r;
    swap_nxt     = swap_r;
    err_nxt      = err_r;
    out_data_nxt = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          x_nxt    = in_a;
          y_nxt    = in_b;
          a_nxt    = in_a;
          b_nxt    = in_b;
          k_nxt    = '0;
          swap_nxt = 1'b0;
          err_nxt  = in_zero;
          acc_nxt  = '0;
        end
      end
      ST_TWOS: begin
        // Strip the common factors of two and count them.
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = {1'b0, x_r[W-1:1]};
          y_nxt = {1'b0, y_r[W-1:1]};
          k_nxt = k_r + 1'b1;
        end
      end
      ST_REDUCE: begin
        // Halve an even value, or replace the larger odd one by half the
        // difference; a wrong guess at the order flips the operand swap.
        if (!xy_equal) begin
          if (!x_r[0]) begin
            x_nxt = {1'b0, x_r[W-1:1]};
          end else if (!y_r[0]) begin
            y_nxt = {1'b0, y_r[W-1:1]};
          end else if (alu_rsp.flag) begin
            swap_nxt = !swap_r;
          end else if (swap_r) begin
            y_nxt = diff_half;
          end else begin
            x_nxt = diff_half;
          end
        end
      end
      ST_SCALE: begin
        // Restore the common factors of two; then set up the divide.
        if (k_r != '0) begin
          x_nxt = {x_r[W-2:0], 1'b0};
          k_nxt = k_r - 1'b1;
        end else begin
          q_nxt   = a_r;
          rem_nxt = '0;
          cnt_nxt = '0;
        end
      end
      ST_DIV: begin
        // Restoring divide of a by the divisor held in x.
        if (alu_rsp.flag) begin
          rem_nxt = trial[W-1:0];
        end else begin
          rem_nxt = alu_rsp.res[W-1:0];
        end
        q_nxt   = {q_r[W-2:0], !alu_rsp.flag};
        cnt_nxt = last_step ? '0 : cnt_r + 1'b1;
        if (last_step) begin
          acc_nxt = '0;
        end
      end
      ST_MUL: begin
        // Shift-add multiply of the quotient by b, most significant bit first.
        acc_nxt = alu_rsp.res;
        q_nxt   = {q_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
      ST_DONE: begin
        if (out_load) begin
          out_data_nxt.operand_error = err_r;
          out_data_nxt.gcd_value     = err_r ? '0 : 32'(x_r);
          out_data_nxt.lcm_value     = err_r ? '0 : 64'(acc_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Result valid: set when a result is loaded, held while stalled.
  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath and payload registers.
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    k_r        <= k_nxt;
    cnt_r      <= cnt_nxt;
    swap_r     <= swap_nxt;
    err_r      <= err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // An accepted transaction always starts the sequencer.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("accepted transaction did not start the sequencer");

  // The odd reduction never sees a zero operand.
  a_reduce_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REDUCE) |-> ((x_r != '0) && (y_r != '0)))
    else $error("zero operand in GCD reduction");

  // A result without an error flag carries a nonzero divisor and multiple.
  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.operand_error) |->
      ((out_data.gcd_value != '0) && (out_data.lcm_value != '0)))
    else $error("valid result with zero divisor or multiple");

  // A new result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !out_load)
    else $error("stalled result overwritten");
`endif

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for gcd_lcm_unit: directed, random, shared-factor,
// back-pressure and streaming operand pairs, every result checked against a
// GCD / LCM predictor. Depends on gcdlcm_pkg and the gcd_lcm_unit RTL.
`timescale 1ns / 1ps

module testbench;
  import gcdlcm_pkg::*;

  localparam int    DRAIN_CYCLES = 6 * OPERAND_WIDTH + 8;
  localparam int    HOLD_CYCLES  = 300;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Expected results in order of acceptance, and run statistics.
  out_item_t   pending_results[$];
  out_item_t   oldest_result;
  int unsigned error_count     = 0;
  int unsigned pairs_sent      = 0;
  int unsigned zero_pairs_sent = 0;
  int unsigned results_checked = 0;

  // Idling controls for the two channels.
  bit          tx_idle_on    = 1'b1;
  bit          rx_idle_on    = 1'b1;
  bit          results_held  = 1'b0;
  int unsigned stall_budget  = 0;

  gcd_lcm_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock with a 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicts the result of one operand pair: Euclid for the divisor and
  // (a/g)*b for the multiple, with operands cut to OPERAND_WIDTH bits.
  function automatic out_item_t predict_gcd_lcm(input in_item_t item);
    logic [63:0] keep_mask;
    logic [63:0] a_val;
    logic [63:0] b_val;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    out_item_t   res;
    keep_mask = (64'd1 << OPERAND_WIDTH) - 64'd1;
    a_val     = {32'd0, item.first_operand} & keep_mask;
    b_val     = {32'd0, item.second_operand} & keep_mask;
    res       = '0;
    if (a_val == 64'd0 || b_val == 64'd0) begin
      res.operand_error = 1'b1;
    end else begin
      x = a_val;
      y = b_val;
      while (y != 64'd0) begin
        r = x % y;
        x = y;
        y = r;
      end
      res.gcd_value = x[31:0];
      res.lcm_value = (a_val / x) * b_val;
    end
    return res;
  endfunction

  // Offers one operand pair after a random gap and returns once the
  // transaction has been accepted. Valid stays high into the next call.
  task automatic send_operands(input logic [31:0] a_opnd, input logic [31:0] b_opnd);
    int unsigned gap;
    in_item_t    item;
    out_item_t   predicted;
    gap                 = tx_idle_on ? $urandom_range(0, 3) : 0;
    item.first_operand  = a_opnd;
    item.second_operand = b_opnd;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = predict_gcd_lcm(item);
    pending_results.push_back(predicted);
    pairs_sent++;
    if (predicted.operand_error) zero_pairs_sent++;
  endtask

  // Operand with a mix of shapes: full range, small, powers of two,
  // near the top, shifted down, and now and then zero.
  function automatic logic [31:0] draw_operand();
    logic [31:0] v;
    case ($urandom_range(0, 19))
      0:       v = 32'd0;
      1, 2:    v = $urandom_range(1, 255);
      3, 4:    v = 32'd1 << $urandom_range(0, 31);
      5:       v = 32'hFFFF_FFFF - $urandom_range(0, 15);
      6, 7, 8: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Extremes, zero operands, equal and dividing pairs, large coprimes.
  task automatic test_edge_operands();
    send_operands(32'd1, 32'd1);
    send_operands(32'd0, 32'd0);
    send_operands(32'd0, 32'd5);
    send_operands(32'd7, 32'd0);
    send_operands(32'd0, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'd1);
    send_operands(32'd1, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'h8000_0000, 32'h8000_0000);
    send_operands(32'h8000_0000, 32'd1);
    send_operands(32'h8000_0000, 32'hFFFF_FFFF);
    send_operands(32'h8000_0000, 32'hC000_0000);
    send_operands(32'd4294967291, 32'd4294967279);
    send_operands(32'd12, 32'd18);
    send_operands(32'd18, 32'd12);
    send_operands(32'd48, 32'd180);
    send_operands(32'd6, 32'd35);
    send_operands(32'hFFFF_0000, 32'h0000_FFFF);
    send_operands(32'hAAAA_AAAA, 32'h5555_5555);
    send_operands(32'd3, 32'hFFFF_FFFD);
    send_operands(32'd65536, 32'd65537);
  endtask

  // Independent random operands.
  task automatic test_random_operands(input int unsigned count);
    repeat (count) send_operands(draw_operand(), draw_operand());
  endtask

  // Pairs built from a common factor, including equal and dividing pairs,
  // so that the divisor is rarely one.
  task automatic test_shared_factors(input int unsigned count);
    logic [31:0] g;
    logic [31:0] x;
    logic [31:0] y;
    repeat (count) begin
      g = ($urandom >> $urandom_range(8, 31)) | 32'd1;
      g = g << $urandom_range(0, 8);
      if (g == 32'd0) g = 32'd1;
      x = $urandom_range(1, 32'hFFFF_FFFF / g);
      y = $urandom_range(1, 32'hFFFF_FFFF / g);
      case ($urandom_range(0, 9))
        0:       send_operands(g * x, g * x);
        1:       send_operands(g, g * y);
        2:       send_operands(g * x, g);
        3:       send_operands(g * x, 32'd0);
        default: send_operands(g * x, g * y);
      endcase
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming,
  // so the unit fills up and stalls its input.
  task automatic test_result_backpressure(input int unsigned count);
    fork
      begin
        @(posedge clk);
        results_held = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        results_held = 1'b0;
      end
    join_none
    repeat (count) send_operands(draw_operand(), draw_operand());
  endtask

  // Back-to-back transactions with no idling on either side.
  task automatic test_streaming(input int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_operands(draw_operand(), draw_operand());
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Receiver stall: a long hold when asked, else a random count of stall
  // cycles per result, used up only while a result is offered.
  always @(negedge clk) begin
    if (results_held) begin
      out_stall <= 1'b1;
    end else if (stall_budget != 0) begin
      out_stall <= 1'b1;
      if (out_valid) stall_budget <= stall_budget - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compares every accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending: gcd %0d lcm %0d error %0b",
                 $time, out_data.gcd_value, out_data.lcm_value, out_data.operand_error);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_data.gcd_value !== oldest_result.gcd_value) begin
          $display("%0t: gcd_value expected %0d actual %0d",
                   $time, oldest_result.gcd_value, out_data.gcd_value);
          error_count++;
        end
        if (out_data.lcm_value !== oldest_result.lcm_value) begin
          $display("%0t: lcm_value expected %0d actual %0d",
                   $time, oldest_result.lcm_value, out_data.lcm_value);
          error_count++;
        end
        if (out_data.operand_error !== oldest_result.operand_error) begin
          $display("%0t: operand_error expected %0b actual %0b",
                   $time, oldest_result.operand_error, out_data.operand_error);
          error_count++;
        end
      end
      stall_budget <= rx_idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // Run-time limit.
  initial begin
    #(RUN_LIMIT_NS);
    $display("%0t: run timed out with %0d results pending", $time, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Reset, the test sequence, drain and final verdict.
  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_edge_operands();
    test_random_operands(1000);
    test_shared_factors(580);
    test_result_backpressure(100);
    test_streaming(200);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d operand pairs (%0d with a zero operand), checked %0d results,",
             pairs_sent, zero_pairs_sent, results_checked);
    $display("with random gaps on both channels, a streaming stretch and a long result hold.");
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
